[sv/costmap_to_global_grid_merge_unit_defines.svh]
// Assertion macros shared by the grid merge unit.
`ifndef COSTMAP_TO_GLOBAL_GRID_MERGE_UNIT_DEFINES_SVH
`define COSTMAP_TO_GLOBAL_GRID_MERGE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CTGGM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CTGGM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTGGM_ASSERT(lbl, clk, rst, prop, msg)
`define CTGGM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[sv/ctggm_pkg.sv]
// Package with sizes, codes and helpers of the grid merge unit.
package ctggm_pkg;

   localparam int GRID_SIZE    = 256;
   localparam int LOCAL_SIZE   = 1024;
   localparam int CORDIC_STEPS = 16;

   localparam int GRID_DEPTH = GRID_SIZE * GRID_SIZE;
   localparam int IDX_W      = $clog2(GRID_DEPTH);
   localparam int GRID_W     = $clog2(GRID_SIZE);
   localparam int STEP_W     = 5;

   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = 68;
   localparam int CV_W   = 34;
   localparam int CS_W   = 20;
   localparam int TRIG_W = 18;
   localparam int LX_W   = 44;
   localparam int NUM_W  = 47;

   localparam int     GAIN_INV = 39797;
   localparam int     TRIG_ONE = 65536;
   localparam longint ONE_Q28  = 64'sd1 << 28;

   typedef enum logic [1:0] {
      OP_POSE = 2'd0,
      OP_CELL = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CSR_MAP_RES   = 3'd0,
      CSR_MOVE_THR  = 3'd1,
      CSR_ORIGIN_X  = 3'd2,
      CSR_ORIGIN_Y  = 3'd3,
      CSR_LOCAL_RES = 3'd4
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIST,
      ST_QUAT,
      ST_ROT,
      ST_CELL,
      ST_CHECK,
      ST_DIV,
      ST_MRD,
      ST_MWR,
      ST_RD,
      ST_RDD,
      ST_DONE
   } state_type;

   // Saturates a CORDIC output to the stored trigonometric width.
   function automatic logic signed [TRIG_W-1:0] clamp_trig(input logic signed [CS_W-1:0] v);
      logic signed [CS_W-1:0] hi;
      logic signed [CS_W-1:0] lo;
      hi = CS_W'((64'sd1 <<< (TRIG_W - 1)) - 64'sd1);
      lo = -CS_W'(64'sd1 <<< (TRIG_W - 1));
      if (v > hi) begin
         clamp_trig = hi[TRIG_W-1:0];
      end else if (v < lo) begin
         clamp_trig = lo[TRIG_W-1:0];
      end else begin
         clamp_trig = v[TRIG_W-1:0];
      end
   endfunction

endpackage

[sv/ctggm_ram.sv]
// Generic simple dual port RAM with a registered read port.
module ctggm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

[sv/costmap_to_global_grid_merge_unit.sv]
// Top level of the occupancy grid merge unit.
//
// Items enter on the req_ channel and one result per item leaves on the rsp_ channel,
// both valid/ready. The csr_ channel writes the five configuration registers by index;
// it is always ready and should only be used while the block is idle.
// The unit works on one item at a time and is not ready while an item is in progress.
// A shared 33x33 multiplier and a small sequencer do the work. Each item runs through
// these steps up to the loaded result, and the sequencer returns to idle before the next item is taken:
//   pose items run a movement check (not on the first pose) and the quaternion setup,
//   then 16 CORDIC steps; a pose that moved less than the move threshold is rejected,
//   cell items run a multiply-accumulate, one range check and
//   8 quotient steps, then a read-modify-write of the grid,
//   read items do a registered read of the grid.
// A finished result sits in an output register; the next item is accepted while it
// waits, and the sequencer holds its own result until the receiver takes the previous one.
// After reset the grid memory is cleared to unknown one entry per cycle, all 65536 entries,
// during which no item is accepted; configuration writes are taken throughout.
`include "costmap_to_global_grid_merge_unit_defines.svh"
module costmap_to_global_grid_merge_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [15:0] req_quat_w,
   input  logic [9:0]         req_cell_col,
   input  logic [9:0]         req_cell_row,
   input  logic signed [7:0]  req_cell_cost,
   input  logic [7:0]         req_map_col,
   input  logic [7:0]         req_map_row,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_pose_accepted,
   output logic               rsp_cell_written,
   output logic [15:0]        rsp_written_index,
   output logic signed [7:0]  rsp_map_value
);

   localparam int MW = ctggm_pkg::MUL_W;
   localparam int PW = ctggm_pkg::PROD_W;
   localparam int AW = ctggm_pkg::ACC_W;
   localparam int VW = ctggm_pkg::CV_W;
   localparam int SW = ctggm_pkg::CS_W;
   localparam int TW = ctggm_pkg::TRIG_W;
   localparam int LW = ctggm_pkg::LX_W;
   localparam int NW = ctggm_pkg::NUM_W;
   localparam int IW = ctggm_pkg::IDX_W;
   localparam int GW = ctggm_pkg::GRID_W;
   localparam int KW = ctggm_pkg::STEP_W;

   ctggm_pkg::state_type state_ff, state_in;
   logic [KW-1:0] step_ff, step_in;
   logic [IW-1:0] clr_ff, clr_in;

   logic [31:0] map_res_ff, map_res_in, move_thr_ff, move_thr_in;
   logic [31:0] org_x_ff, org_x_in, org_y_ff, org_y_in, loc_res_ff, loc_res_in;

   ctggm_pkg::op_type op_ff, op_in;
   logic signed [31:0] px_ff, px_in, py_ff, py_in;
   logic signed [15:0] qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in, qw_ff, qw_in;
   logic [9:0] col_ff, col_in, row_ff, row_in;
   logic signed [7:0] cost_ff, cost_in;
   logic [7:0] mcol_ff, mcol_in, mrow_ff, mrow_in;

   logic signed [31:0] last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic have_last_ff, have_last_in, merge_open_ff, merge_open_in;
   logic signed [TW-1:0] cos_ff, cos_in, sin_ff, sin_in;

   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [VW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [SW-1:0] cc_ff, cc_in, cs_ff, cs_in;
   logic flip_ff, flip_in;
   logic signed [LW-1:0] lx_ff, lx_in, ly_ff, ly_in;
   logic signed [NW-1:0] num_x_ff, num_x_in, num_y_ff, num_y_in;
   logic [GW-1:0] gx_ff, gx_in, gy_ff, gy_in;

   logic res_pose_ff, res_pose_in, res_cell_ff, res_cell_in;
   logic [IW-1:0] res_idx_ff, res_idx_in;
   logic signed [7:0] res_val_ff, res_val_in;

   logic rsp_valid_ff, rsp_valid_in, rsp_pose_ff, rsp_pose_in, rsp_cell_ff, rsp_cell_in;
   logic [15:0] rsp_idx_ff, rsp_idx_in;
   logic signed [7:0] rsp_val_ff, rsp_val_in;

   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [AW-1:0] prod_ext, prod_hi, acc_plus;
   logic signed [32:0] dx, dy, adx, ady;
   logic signed [VW-1:0] nx, ny;
   logic signed [SW-1:0] nc, ns, fc, fs;
   logic signed [NW-1:0] half_w, mag_x, mag_y, div_w;
   logic [NW-1:0] lim_w;
   logic in_x, in_y;
   logic [IW-1:0] idx_w, rd_idx_w;
   logic ram_we;
   logic [IW-1:0] ram_waddr, ram_raddr;
   logic [7:0] ram_wdata, ram_rdata;
   logic signed [7:0] old_val, new_val;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_pose_accepted = rsp_pose_ff;
   assign rsp_cell_written = rsp_cell_ff;
   assign rsp_written_index = rsp_idx_ff;
   assign rsp_map_value = rsp_val_ff;

   assign prod_in  = mul_a * mul_b;
   assign prod_ext = AW'(prod_ff);
   assign prod_hi  = prod_ext <<< 32;
   assign acc_plus = acc_ff + prod_ext;

   assign dx  = 33'(px_ff) - 33'(last_x_ff);
   assign dy  = 33'(py_ff) - 33'(last_y_ff);
   assign adx = dx[32] ? -dx : dx;
   assign ady = dy[32] ? -dy : dy;

   assign nx = (cy_ff > 0) ? cx_ff + (cy_ff >>> step_ff) : cx_ff - (cy_ff >>> step_ff);
   assign ny = (cy_ff > 0) ? cy_ff - (cx_ff >>> step_ff) : cy_ff + (cx_ff >>> step_ff);
   assign nc = (cy_ff > 0) ? cc_ff - (cs_ff >>> step_ff) : cc_ff + (cs_ff >>> step_ff);
   assign ns = (cy_ff > 0) ? cs_ff + (cc_ff >>> step_ff) : cs_ff - (cc_ff >>> step_ff);
   assign fc = flip_ff ? -nc : nc;
   assign fs = flip_ff ? -ns : ns;

   assign half_w = $signed((NW'(map_res_ff) * NW'(ctggm_pkg::GRID_SIZE)) >> 1);
   assign lim_w  = NW'(map_res_ff) * NW'(ctggm_pkg::GRID_SIZE);
   assign mag_x  = -num_x_ff;
   assign mag_y  = -num_y_ff;
   assign in_x   = num_x_ff[NW-1] ? ($unsigned(mag_x) < NW'(map_res_ff))
                                  : ($unsigned(num_x_ff) < lim_w);
   assign in_y   = num_y_ff[NW-1] ? ($unsigned(mag_y) < NW'(map_res_ff))
                                  : ($unsigned(num_y_ff) < lim_w);
   assign div_w  = $signed(NW'(map_res_ff) << step_ff);

   assign idx_w    = IW'(gy_ff) * IW'(ctggm_pkg::GRID_SIZE) + IW'(gx_ff);
   assign rd_idx_w = IW'(mrow_ff) * IW'(ctggm_pkg::GRID_SIZE) + IW'(mcol_ff);
   assign old_val  = $signed(ram_rdata);
   assign new_val  = (cost_ff > old_val) ? cost_ff : old_val;

   ctggm_ram #(
      .WIDTH(8),
      .DEPTH(ctggm_pkg::GRID_DEPTH)
   ) u_grid (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ctggm_pkg::ST_DIST: begin
            unique case (step_ff)
               KW'(0): begin mul_a = adx; mul_b = adx; end
               KW'(1): begin mul_a = ady; mul_b = ady; end
               default: begin
                  mul_a = $signed({1'b0, move_thr_ff});
                  mul_b = $signed({1'b0, move_thr_ff});
               end
            endcase
         end
         ctggm_pkg::ST_QUAT: begin
            unique case (step_ff)
               KW'(0): begin mul_a = MW'(qw_ff); mul_b = MW'(qz_ff); end
               KW'(1): begin mul_a = MW'(qx_ff); mul_b = MW'(qy_ff); end
               KW'(2): begin mul_a = MW'(qy_ff); mul_b = MW'(qy_ff); end
               default: begin mul_a = MW'(qz_ff); mul_b = MW'(qz_ff); end
            endcase
         end
         ctggm_pkg::ST_CELL: begin
            unique case (step_ff)
               KW'(0): begin
                  mul_a = $signed(MW'({col_ff, 1'b1}));
                  mul_b = $signed({1'b0, loc_res_ff});
               end
               KW'(1): begin
                  mul_a = $signed(MW'({row_ff, 1'b1}));
                  mul_b = $signed({1'b0, loc_res_ff});
               end
               KW'(2): begin mul_a = $signed({1'b0, lx_ff[31:0]}); mul_b = MW'(cos_ff); end
               KW'(3): begin mul_a = MW'($signed(lx_ff[LW-1:32])); mul_b = MW'(cos_ff); end
               KW'(4): begin mul_a = $signed({1'b0, ly_ff[31:0]}); mul_b = MW'(sin_ff); end
               KW'(5): begin mul_a = MW'($signed(ly_ff[LW-1:32])); mul_b = MW'(sin_ff); end
               KW'(6): begin mul_a = $signed({1'b0, lx_ff[31:0]}); mul_b = MW'(sin_ff); end
               KW'(7): begin mul_a = MW'($signed(lx_ff[LW-1:32])); mul_b = MW'(sin_ff); end
               KW'(8): begin mul_a = $signed({1'b0, ly_ff[31:0]}); mul_b = MW'(cos_ff); end
               KW'(9): begin mul_a = MW'($signed(ly_ff[LW-1:32])); mul_b = MW'(cos_ff); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      clr_in = clr_ff;
      map_res_in = map_res_ff;
      move_thr_in = move_thr_ff;
      org_x_in = org_x_ff;
      org_y_in = org_y_ff;
      loc_res_in = loc_res_ff;
      op_in = op_ff;
      px_in = px_ff;
      py_in = py_ff;
      qx_in = qx_ff;
      qy_in = qy_ff;
      qz_in = qz_ff;
      qw_in = qw_ff;
      col_in = col_ff;
      row_in = row_ff;
      cost_in = cost_ff;
      mcol_in = mcol_ff;
      mrow_in = mrow_ff;
      last_x_in = last_x_ff;
      last_y_in = last_y_ff;
      have_last_in = have_last_ff;
      merge_open_in = merge_open_ff;
      cos_in = cos_ff;
      sin_in = sin_ff;
      acc_in = acc_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      cc_in = cc_ff;
      cs_in = cs_ff;
      flip_in = flip_ff;
      lx_in = lx_ff;
      ly_in = ly_ff;
      num_x_in = num_x_ff;
      num_y_in = num_y_ff;
      gx_in = gx_ff;
      gy_in = gy_ff;
      res_pose_in = res_pose_ff;
      res_cell_in = res_cell_ff;
      res_idx_in = res_idx_ff;
      res_val_in = res_val_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pose_in = rsp_pose_ff;
      rsp_cell_in = rsp_cell_ff;
      rsp_idx_in = rsp_idx_ff;
      rsp_val_in = rsp_val_ff;
      req_ready = 1'b0;
      ram_we = 1'b0;
      ram_waddr = idx_w;
      ram_wdata = new_val;
      ram_raddr = idx_w;

      if (csr_valid) begin
         unique case (csr_index)
            ctggm_pkg::CSR_MAP_RES:   map_res_in = csr_wdata;
            ctggm_pkg::CSR_MOVE_THR:  move_thr_in = csr_wdata;
            ctggm_pkg::CSR_ORIGIN_X:  org_x_in = csr_wdata;
            ctggm_pkg::CSR_ORIGIN_Y:  org_y_in = csr_wdata;
            ctggm_pkg::CSR_LOCAL_RES: loc_res_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ctggm_pkg::ST_CLEAR: begin
            ram_we = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = 8'hFF;
            clr_in = clr_ff + IW'(1);
            if (clr_ff == IW'(ctggm_pkg::GRID_DEPTH - 1)) begin
               state_in = ctggm_pkg::ST_IDLE;
            end
         end
         ctggm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in = ctggm_pkg::op_type'(req_op);
               px_in = req_pos_x;
               py_in = req_pos_y;
               qx_in = req_quat_x;
               qy_in = req_quat_y;
               qz_in = req_quat_z;
               qw_in = req_quat_w;
               col_in = req_cell_col;
               row_in = req_cell_row;
               cost_in = req_cell_cost;
               mcol_in = req_map_col;
               mrow_in = req_map_row;
               res_pose_in = 1'b0;
               res_cell_in = 1'b0;
               res_idx_in = '0;
               res_val_in = '0;
               step_in = '0;
               unique case (ctggm_pkg::op_type'(req_op))
                  ctggm_pkg::OP_POSE: begin
                     state_in = have_last_ff ? ctggm_pkg::ST_DIST : ctggm_pkg::ST_QUAT;
                  end
                  ctggm_pkg::OP_CELL: begin
                     if (merge_open_ff && req_cell_cost > 0 && map_res_ff != 32'd0 &&
                         32'(req_cell_col) < 32'(ctggm_pkg::LOCAL_SIZE) &&
                         32'(req_cell_row) < 32'(ctggm_pkg::LOCAL_SIZE)) begin
                        state_in = ctggm_pkg::ST_CELL;
                     end else begin
                        state_in = ctggm_pkg::ST_DONE;
                     end
                  end
                  ctggm_pkg::OP_READ: state_in = ctggm_pkg::ST_RD;
                  default: state_in = ctggm_pkg::ST_DONE;
               endcase
            end
         end
         ctggm_pkg::ST_DIST: begin
            step_in = step_ff + KW'(1);
            unique case (step_ff)
               KW'(0): ;
               KW'(1): acc_in = prod_ext;
               KW'(2): acc_in = acc_plus;
               default: begin
                  step_in = '0;
                  if (acc_ff >= prod_ext) begin
                     state_in = ctggm_pkg::ST_QUAT;
                  end else begin
                     merge_open_in = 1'b0;
                     state_in = ctggm_pkg::ST_DONE;
                  end
               end
            endcase
         end
         ctggm_pkg::ST_QUAT: begin
            step_in = step_ff + KW'(1);
            unique case (step_ff)
               KW'(0): ;
               KW'(1): acc_in = prod_ext;
               KW'(2): cy_in = VW'(acc_plus <<< 1);
               KW'(3): acc_in = prod_ext;
               KW'(4): cx_in = VW'(AW'(ctggm_pkg::ONE_Q28) - (acc_plus <<< 1));
               default: begin
                  step_in = '0;
                  if (cx_ff == '0 && cy_ff == '0) begin
                     cos_in = TW'(ctggm_pkg::TRIG_ONE);
                     sin_in = '0;
                     last_x_in = px_ff;
                     last_y_in = py_ff;
                     have_last_in = 1'b1;
                     merge_open_in = 1'b1;
                     res_pose_in = 1'b1;
                     state_in = ctggm_pkg::ST_DONE;
                  end else begin
                     flip_in = cx_ff[VW-1];
                     if (cx_ff[VW-1]) begin
                        cx_in = -cx_ff;
                        cy_in = -cy_ff;
                     end
                     cc_in = SW'(ctggm_pkg::GAIN_INV);
                     cs_in = '0;
                     state_in = ctggm_pkg::ST_ROT;
                  end
               end
            endcase
         end
         ctggm_pkg::ST_ROT: begin
            cx_in = nx;
            cy_in = ny;
            cc_in = nc;
            cs_in = ns;
            step_in = step_ff + KW'(1);
            if (step_ff == KW'(ctggm_pkg::CORDIC_STEPS - 1)) begin
               cos_in = ctggm_pkg::clamp_trig(fc);
               sin_in = ctggm_pkg::clamp_trig(fs);
               last_x_in = px_ff;
               last_y_in = py_ff;
               have_last_in = 1'b1;
               merge_open_in = 1'b1;
               res_pose_in = 1'b1;
               state_in = ctggm_pkg::ST_DONE;
            end
         end
         ctggm_pkg::ST_CELL: begin
            step_in = step_ff + KW'(1);
            unique case (step_ff)
               KW'(0): ;
               KW'(1): lx_in = LW'($signed(org_x_ff)) + LW'(prod_ff >>> 1);
               KW'(2): ly_in = LW'($signed(org_y_ff)) + LW'(prod_ff >>> 1);
               KW'(3): acc_in = prod_ext;
               KW'(4): acc_in = acc_ff + prod_hi;
               KW'(5): acc_in = acc_ff - prod_ext;
               KW'(6): acc_in = acc_ff - prod_hi;
               KW'(7): begin
                  num_x_in = NW'(last_x_ff) + NW'(acc_ff >>> 16);
                  acc_in = prod_ext;
               end
               KW'(8): acc_in = acc_ff + prod_hi;
               KW'(9): acc_in = acc_ff + prod_ext;
               KW'(10): acc_in = acc_ff + prod_hi;
               KW'(11): begin
                  num_y_in = NW'(last_y_ff) + NW'(acc_ff >>> 16);
                  num_x_in = num_x_ff + half_w;
               end
               default: begin
                  num_y_in = num_y_ff + half_w;
                  state_in = ctggm_pkg::ST_CHECK;
               end
            endcase
         end
         ctggm_pkg::ST_CHECK: begin
            if (in_x && in_y) begin
               if (num_x_ff[NW-1]) begin
                  num_x_in = '0;
               end
               if (num_y_ff[NW-1]) begin
                  num_y_in = '0;
               end
               gx_in = '0;
               gy_in = '0;
               step_in = KW'(GW - 1);
               state_in = ctggm_pkg::ST_DIV;
            end else begin
               state_in = ctggm_pkg::ST_DONE;
            end
         end
         ctggm_pkg::ST_DIV: begin
            if (num_x_ff >= div_w) begin
               num_x_in = num_x_ff - div_w;
               gx_in = {gx_ff[GW-2:0], 1'b1};
            end else begin
               gx_in = {gx_ff[GW-2:0], 1'b0};
            end
            if (num_y_ff >= div_w) begin
               num_y_in = num_y_ff - div_w;
               gy_in = {gy_ff[GW-2:0], 1'b1};
            end else begin
               gy_in = {gy_ff[GW-2:0], 1'b0};
            end
            step_in = step_ff - KW'(1);
            if (step_ff == '0) begin
               state_in = ctggm_pkg::ST_MRD;
            end
         end
         ctggm_pkg::ST_MRD: begin
            state_in = ctggm_pkg::ST_MWR;
         end
         ctggm_pkg::ST_MWR: begin
            ram_we = 1'b1;
            res_cell_in = 1'b1;
            res_idx_in = idx_w;
            res_val_in = new_val;
            state_in = ctggm_pkg::ST_DONE;
         end
         ctggm_pkg::ST_RD: begin
            ram_raddr = rd_idx_w;
            if (32'(mcol_ff) < 32'(ctggm_pkg::GRID_SIZE) &&
                32'(mrow_ff) < 32'(ctggm_pkg::GRID_SIZE)) begin
               state_in = ctggm_pkg::ST_RDD;
            end else begin
               res_val_in = 8'shFF;
               state_in = ctggm_pkg::ST_DONE;
            end
         end
         ctggm_pkg::ST_RDD: begin
            res_val_in = old_val;
            state_in = ctggm_pkg::ST_DONE;
         end
         ctggm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pose_in = res_pose_ff;
               rsp_cell_in = res_cell_ff;
               rsp_idx_in = 16'(res_idx_ff);
               rsp_val_in = res_val_ff;
               state_in = ctggm_pkg::ST_IDLE;
            end
         end
         default: state_in = ctggm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ctggm_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         clr_ff <= '0;
         map_res_ff <= 32'd6554;
         move_thr_ff <= 32'd6554;
         org_x_ff <= '0;
         org_y_ff <= '0;
         loc_res_ff <= 32'd6554;
         last_x_ff <= '0;
         last_y_ff <= '0;
         have_last_ff <= 1'b0;
         merge_open_ff <= 1'b0;
         cos_ff <= '0;
         sin_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         clr_ff <= clr_in;
         map_res_ff <= map_res_in;
         move_thr_ff <= move_thr_in;
         org_x_ff <= org_x_in;
         org_y_ff <= org_y_in;
         loc_res_ff <= loc_res_in;
         last_x_ff <= last_x_in;
         last_y_ff <= last_y_in;
         have_last_ff <= have_last_in;
         merge_open_ff <= merge_open_in;
         cos_ff <= cos_in;
         sin_ff <= sin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      px_ff <= px_in;
      py_ff <= py_in;
      qx_ff <= qx_in;
      qy_ff <= qy_in;
      qz_ff <= qz_in;
      qw_ff <= qw_in;
      col_ff <= col_in;
      row_ff <= row_in;
      cost_ff <= cost_in;
      mcol_ff <= mcol_in;
      mrow_ff <= mrow_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      cc_ff <= cc_in;
      cs_ff <= cs_in;
      flip_ff <= flip_in;
      lx_ff <= lx_in;
      ly_ff <= ly_in;
      num_x_ff <= num_x_in;
      num_y_ff <= num_y_in;
      gx_ff <= gx_in;
      gy_ff <= gy_in;
      res_pose_ff <= res_pose_in;
      res_cell_ff <= res_cell_in;
      res_idx_ff <= res_idx_in;
      res_val_ff <= res_val_in;
      rsp_pose_ff <= rsp_pose_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_val_ff <= rsp_val_in;
   end

   `CTGGM_ASSERT_ALWAYS(a_reset_clear, clock, reset |=> state_ff == ctggm_pkg::ST_CLEAR && !rsp_valid, "Reset must start the clearing pass with no result pending.")
   `CTGGM_ASSERT(a_accept_busy, clock, reset, req_valid && req_ready |=> !req_ready, "The unit must be busy after accepting an item.")
   `CTGGM_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_valid) |-> $past(state_ff == ctggm_pkg::ST_DONE), "A result may only be loaded at the end of an item.")
   `CTGGM_ASSERT(a_merge_gate, clock, reset, ram_we && state_ff == ctggm_pkg::ST_MWR |-> merge_open_ff && op_ff == ctggm_pkg::OP_CELL && cost_ff > 0, "A grid merge needs an open merge and a positive cell cost.")

endmodule
